// ----- sv/gtp_pkg.sv -----
package gtp_pkg;

  // Field widths
  localparam int unsigned POS_W  = 24;
  localparam int unsigned DIFF_W = 25;
  localparam int unsigned ANG_W  = 16;
  localparam int unsigned DIST_W = 25;
  localparam int unsigned MINT_W = 15;

  // One square-root digit per step over a 50-bit radicand
  localparam int unsigned SQRT_STEPS = 25;

  // Angle constants, 1/128 degree, held wide enough for the wrap sums
  localparam logic signed [17:0] ANG_180 = 18'sd23040;
  localparam logic signed [17:0] ANG_360 = 18'sd46080;

  // CORDIC angle accumulator, 1/32768 degree
  localparam int unsigned         Z_W     = 26;
  localparam logic signed [Z_W-1:0] Z_180  = 26'sd5898240;
  localparam logic signed [Z_W-1:0] Z_HALF = 26'sd128;

  // CORDIC datapath width: input scaled by 256 plus gain headroom
  localparam int unsigned XY_W = 36;

  localparam int unsigned TAB_W = 21;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQX  = 6'b000010,
    ST_SQY  = 6'b000100,
    ST_ITER = 6'b001000,
    ST_ANG  = 6'b010000,
    ST_TURN = 6'b100000
  } gtp_state_t;

  // atan(2^-i) in 1/32768 degree
  function automatic logic [TAB_W-1:0] atan_step(input logic [4:0] idx);
    logic [TAB_W-1:0] v;
    case (idx)
      5'd0:    v = 21'd1474560;
      5'd1:    v = 21'd870484;
      5'd2:    v = 21'd459940;
      5'd3:    v = 21'd233473;
      5'd4:    v = 21'd117189;
      5'd5:    v = 21'd58653;
      5'd6:    v = 21'd29333;
      5'd7:    v = 21'd14667;
      5'd8:    v = 21'd7334;
      5'd9:    v = 21'd3667;
      5'd10:   v = 21'd1833;
      5'd11:   v = 21'd917;
      5'd12:   v = 21'd458;
      5'd13:   v = 21'd229;
      5'd14:   v = 21'd115;
      5'd15:   v = 21'd57;
      5'd16:   v = 21'd29;
      5'd17:   v = 21'd14;
      5'd18:   v = 21'd7;
      5'd19:   v = 21'd4;
      5'd20:   v = 21'd2;
      5'd21:   v = 21'd1;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/goto_point_turn_and_distance_unit.sv -----
// Go-to-point turn and distance unit. The block holds a pen position (Q15.8)
// and a heading (1/128 degree, 0 = +Y, positive clockwise). An input word with
// tuser = 1 loads position and heading and makes no result. A word
// with tuser = 0 names a target point; the block returns one word with the
// wrapped turn toward the target, a flag that the turn exceeds min_turn (the
// heading then follows the target), the rounded distance in Q.8 and the pen
// flag. Position always moves to the target. A go-to word passes through the
// accept, the squaring of |dx| and then of |dy| on one shared 24x24 squarer,
// the digit-by-digit square root (the CORDIC vectoring steps run in the same
// iterations on a shared shift-add unit), the rounding and wrap of the angle
// and the forming of the turn. The block is not ready meanwhile.
// The result sits in an output register, so the next word is taken while it
// waits; the turn stage holds only if a second result would overwrite it.
module goto_point_turn_and_distance_unit
  import gtp_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16  // vectoring steps, 8..24
) (
  input  logic        clk,
  input  logic        rst,
  // min_turn register, 1/128 degree
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [23:0] target_x, [47:24] target_y, [63:48] new_heading, [64] pen_down, rest zero
  input  logic [71:0] s_axis_tdata,
  // [0] action
  input  logic        s_axis_tuser,
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] turn_angle, [16] do_turn, [41:17] distance, [42] pen_active, rest zero
  output logic [47:0] m_axis_tdata
);

  localparam int unsigned ITER_STEPS = SQRT_STEPS;
  localparam int unsigned CNT_W      = $clog2(ITER_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(ITER_STEPS - 1);
  localparam logic [CNT_W-1:0] CORDIC_CNT = CNT_W'(CORDIC_STEPS);

  gtp_state_t state;

  // architectural state and configuration
  logic signed [POS_W-1:0]  pos_x, pos_y;
  logic signed [ANG_W-1:0]  heading;
  logic        [MINT_W-1:0] min_turn;

  // per-item working registers
  logic signed [DIFF_W-1:0] dx, dy;
  logic                     pen;
  logic                     zero_vec;
  logic [CNT_W-1:0]         count;
  logic [47:0]              sq_x;
  logic [49:0]              rad;
  logic [27:0]              rem;
  logic [DIST_W-1:0]        root;
  logic signed [XY_W-1:0]   cx, cy;
  logic signed [Z_W-1:0]    cz;
  logic signed [ANG_W-1:0]  ang;
  logic [DIST_W-1:0]        distance;

  // input field unpack
  logic signed [POS_W-1:0] in_x, in_y;
  logic signed [ANG_W-1:0] in_heading;
  assign in_x       = s_axis_tdata[23:0];
  assign in_y       = s_axis_tdata[47:24];
  assign in_heading = s_axis_tdata[63:48];

  logic in_acc;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // shared squarer: |dx| in ST_SQX, |dy| in ST_SQY
  logic [DIFF_W-1:0] dx_abs, dy_abs;
  logic [23:0]       mul_in;
  logic [47:0]       mul_out;
  assign dx_abs  = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign dy_abs  = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  assign mul_in  = (state == ST_SQX) ? dx_abs[23:0] : dy_abs[23:0];
  assign mul_out = mul_in * mul_in;

  // CORDIC start: x = dy*256, y = dx*256, folded into the right half plane
  logic signed [XY_W-1:0] dx_sc, dy_sc;
  assign dx_sc = {{(XY_W-DIFF_W-8){dx[DIFF_W-1]}}, dx, 8'b0};
  assign dy_sc = {{(XY_W-DIFF_W-8){dy[DIFF_W-1]}}, dy, 8'b0};

  // shared shift-add step
  logic signed [XY_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  tab;
  assign xs  = cx >>> count;
  assign ys  = cy >>> count;
  assign tab = signed'({{(Z_W-TAB_W){1'b0}}, atan_step(5'(count))});

  // square-root digit
  logic [27:0] rem_sh, trial;
  assign rem_sh = {rem[25:0], rad[49:48]};
  assign trial  = {1'b0, root, 2'b01};

  // angle rounding and wrap into (-180, 180]
  logic signed [Z_W-1:0] z_rnd;
  logic signed [17:0]    a_raw, a_wrap;
  assign z_rnd = cz + Z_HALF;
  assign a_raw = 18'(z_rnd >>> 8);
  always_comb begin
    if (a_raw > ANG_180) begin
      a_wrap = a_raw - ANG_360;
    end else if (a_raw <= -ANG_180) begin
      a_wrap = a_raw + ANG_360;
    end else begin
      a_wrap = a_raw;
    end
  end

  // turn toward target, wrapped into [-180, 180]
  logic signed [17:0] t_raw, t_wrap, t_mag;
  logic               flag;
  assign t_raw = {{2{ang[ANG_W-1]}}, ang} - {{2{heading[ANG_W-1]}}, heading};
  always_comb begin
    if (t_raw > ANG_180) begin
      t_wrap = t_raw - ANG_360;
    end else if (t_raw < -ANG_180) begin
      t_wrap = t_raw + ANG_360;
    end else begin
      t_wrap = t_raw;
    end
  end
  assign t_mag = t_wrap[17] ? -t_wrap : t_wrap;
  assign flag  = t_mag[15:0] > {1'b0, min_turn};

  logic out_free;
  logic res_load;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign res_load = (state == ST_TURN) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pos_x         <= '0;
      pos_y         <= '0;
      heading       <= '0;
      min_turn      <= 15'd128;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_turn <= cfg_wdata;
      end
      // load a fresh result from the turn stage, else drop the one taken
      if (res_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            pos_x <= in_x;
            pos_y <= in_y;
            if (s_axis_tuser) begin
              heading <= in_heading;
            end else begin
              dx    <= {in_x[POS_W-1], in_x} - {pos_x[POS_W-1], pos_x};
              dy    <= {in_y[POS_W-1], in_y} - {pos_y[POS_W-1], pos_y};
              pen   <= s_axis_tdata[64];
              state <= ST_SQX;
            end
          end
        end
        ST_SQX: begin
          sq_x     <= mul_out;
          zero_vec <= (dx == '0) && (dy == '0);
          if (dy[DIFF_W-1]) begin
            cx <= -dy_sc;
            cy <= -dx_sc;
            cz <= dx[DIFF_W-1] ? -Z_180 : Z_180;
          end else begin
            cx <= dy_sc;
            cy <= dx_sc;
            cz <= '0;
          end
          state <= ST_SQY;
        end
        ST_SQY: begin
          rad   <= {2'b0, sq_x} + {2'b0, mul_out};
          rem   <= '0;
          root  <= '0;
          count <= '0;
          state <= ST_ITER;
        end
        ST_ITER: begin
          // one root digit per cycle
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[DIST_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[DIST_W-2:0], 1'b0};
          end
          rad <= {rad[47:0], 2'b00};
          // vectoring step, rotate toward y = 0
          if (count < CORDIC_CNT) begin
            if (!cy[XY_W-1]) begin
              cx <= cx + ys;
              cy <= cy - xs;
              cz <= cz + tab;
            end else begin
              cx <= cx - ys;
              cy <= cy + xs;
              cz <= cz - tab;
            end
          end
          if (count == CNT_LAST) begin
            state <= ST_ANG;
          end else begin
            count <= count + 1'b1;
          end
        end
        ST_ANG: begin
          ang      <= zero_vec ? '0 : ANG_W'(a_wrap);
          // round to nearest: remainder above root means the upper half
          distance <= (rem > {3'b0, root}) ? root + 1'b1 : root;
          state    <= ST_TURN;
        end
        ST_TURN: begin
          // hold until the output register is free
          if (out_free) begin
            m_axis_tdata <= {5'b0, pen, distance, flag, t_wrap[15:0]};
            if (flag) begin
              heading <= ang;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a go-to word starts the squarer in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && !s_axis_tuser) |=> (state == ST_SQX))
    else $error("go-to word did not start the sequencer");

  // a result only appears from the turn stage
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_TURN))
    else $error("result raised outside the turn stage");

  // iteration counter stays within the root digits
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ITER) |-> (count <= CNT_LAST))
    else $error("iteration counter overran");

  // a flagged turn is never zero
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[16]) |-> (m_axis_tdata[15:0] != 16'd0))
    else $error("do_turn set on a zero turn");

  // set_position leaves the block idle
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tuser) |=> (state == ST_IDLE))
    else $error("set_position left the idle state");

endmodule
